// ===== hw/rtl/bpg_pkg.sv =====
// ----------------------------------------------------------------------------
// bpg_pkg: shared types and constants of the line pixel generator
// Item structs, the command entry passed from front to back, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package bpg_pkg;

	// coordinate width
	localparam int COORD_BITS = 12;
	// error term: one bit of headroom plus sign
	localparam int ERR_BITS = COORD_BITS + 2;
	// screen size registers
	localparam int REG_BITS = 13;
	localparam int CMP_BITS = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
	localparam int COLOR_BITS = 16;

	// configuration port
	localparam int CFG_ADDR_BITS = 1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_WIDTH  = CFG_ADDR_BITS'(0);
	localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_HEIGHT = CFG_ADDR_BITS'(1);
	localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RST  = REG_BITS'(240);
	localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RST = REG_BITS'(320);

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	typedef enum logic [0:0] {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

	typedef struct packed {
		func_t  func;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		color_t line_color;
	} in_item_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t pixel_color;
		logic   on_screen;
		logic   last_pixel;
	} out_item_t;

	// classified command, load fields already set up for stepping
	typedef struct packed {
		func_t  func;
		coord_t major_start;
		coord_t minor_start;
		coord_t major_end;
		coord_t major_delta;
		coord_t minor_delta;
		logic   minor_down;
		logic   axes_swapped;
		color_t color;
	} cmd_t;

	typedef struct packed {
		logic [REG_BITS-1:0] width;
		logic [REG_BITS-1:0] height;
	} screen_cfg_t;

	typedef struct packed {
		logic drawing;
		logic pop;
		logic emit;
	} back_status_t;

endpackage

// ===== hw/rtl/bpg_front.sv =====
// ----------------------------------------------------------------------------
// bpg_front: item intake and line setup
// Registers each input item, finds the steep case, orders the endpoints and
// forms the deltas, then hands a command to the queue.
// ----------------------------------------------------------------------------
module bpg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bpg_pkg::in_item_t in_item,
	output logic              push_valid,
	input  logic              push_ready,
	output bpg_pkg::cmd_t     push_cmd
);

	function automatic bpg_pkg::coord_t abs_diff(input bpg_pkg::coord_t a,
	                                             input bpg_pkg::coord_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic              valid_s1;
	bpg_pkg::in_item_t item_s1;
	logic              steep_s1;
	logic              steep_d;

	bpg_pkg::coord_t a0, b0, a1, b1;
	bpg_pkg::coord_t maj0, min0, maj1, min1;

	// steep when the row span exceeds the column span
	always_comb begin
		steep_d = abs_diff(in_item.end_y, in_item.start_y) >
		          abs_diff(in_item.end_x, in_item.start_x);
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	// intake stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1  <= in_item;
			steep_s1 <= steep_d;
		end
	end

	// axis swap, endpoint ordering and deltas
	always_comb begin
		if (steep_s1) begin
			a0 = item_s1.start_y;
			b0 = item_s1.start_x;
			a1 = item_s1.end_y;
			b1 = item_s1.end_x;
		end else begin
			a0 = item_s1.start_x;
			b0 = item_s1.start_y;
			a1 = item_s1.end_x;
			b1 = item_s1.end_y;
		end
		if (a0 > a1) begin
			maj0 = a1;
			min0 = b1;
			maj1 = a0;
			min1 = b0;
		end else begin
			maj0 = a0;
			min0 = b0;
			maj1 = a1;
			min1 = b1;
		end
		push_cmd.func         = item_s1.func;
		push_cmd.major_start  = maj0;
		push_cmd.minor_start  = min0;
		push_cmd.major_end    = maj1;
		push_cmd.major_delta  = maj1 - maj0;
		push_cmd.minor_delta  = abs_diff(min1, min0);
		push_cmd.minor_down   = !(min0 < min1);
		push_cmd.axes_swapped = steep_s1;
		push_cmd.color        = item_s1.line_color;
	end

endmodule

// ===== hw/rtl/bpg_queue.sv =====
// ----------------------------------------------------------------------------
// bpg_queue: command queue
// Short first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
module bpg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bpg_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bpg_pkg::cmd_t pop_cmd
);

	localparam logic [bpg_pkg::QPTR_BITS-1:0] LAST_PTR =
		bpg_pkg::QPTR_BITS'(bpg_pkg::QUEUE_DEPTH - 1);
	localparam logic [bpg_pkg::QCNT_BITS-1:0] FULL_COUNT =
		bpg_pkg::QCNT_BITS'(bpg_pkg::QUEUE_DEPTH);

	bpg_pkg::cmd_t                  mem_q [bpg_pkg::QUEUE_DEPTH];
	logic [bpg_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [bpg_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [bpg_pkg::QCNT_BITS-1:0]  count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/bpg_back.sv =====
// ----------------------------------------------------------------------------
// bpg_back: line stepper
// Holds the line state, runs one command per cycle unless a drawing step waits
// for the output register, and drives it with one pixel per drawing step item.
// ----------------------------------------------------------------------------
module bpg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpg_pkg::screen_cfg_t  screen_cfg,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  bpg_pkg::cmd_t         pop_cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bpg_pkg::out_item_t    out_item,
	output bpg_pkg::back_status_t status
);

	bpg_pkg::coord_t                     major_pos_q;
	bpg_pkg::coord_t                     minor_pos_q;
	bpg_pkg::coord_t                     major_end_q;
	bpg_pkg::coord_t                     major_delta_q;
	bpg_pkg::coord_t                     minor_delta_q;
	logic signed [bpg_pkg::ERR_BITS-1:0] error_q;
	logic                                minor_down_q;
	logic                                axes_swapped_q;
	bpg_pkg::color_t                     held_color_q;
	logic                                drawing_q;

	logic                                out_valid_q;
	bpg_pkg::out_item_t                  out_item_q;

	logic                                is_step;
	logic                                out_free;
	logic                                do_pop;
	logic                                emit;
	logic                                last;
	bpg_pkg::coord_t                     px;
	bpg_pkg::coord_t                     py;
	logic                                vis;
	logic signed [bpg_pkg::ERR_BITS-1:0] err_sub;
	logic signed [bpg_pkg::ERR_BITS-1:0] err_add;

	// pop control: a step that draws needs room in the output register
	always_comb begin
		is_step   = (pop_cmd.func == bpg_pkg::FUNC_STEP);
		out_free  = !out_valid_q || out_ready;
		pop_ready = !(is_step && drawing_q) || out_free;
		do_pop    = pop_valid && pop_ready;
		emit      = do_pop && is_step && drawing_q;
	end

	// current pixel and next error term
	always_comb begin
		px      = axes_swapped_q ? minor_pos_q : major_pos_q;
		py      = axes_swapped_q ? major_pos_q : minor_pos_q;
		last    = (major_pos_q == major_end_q);
		vis     = (bpg_pkg::CMP_BITS'(px) < bpg_pkg::CMP_BITS'(screen_cfg.width)) &&
		          (bpg_pkg::CMP_BITS'(py) < bpg_pkg::CMP_BITS'(screen_cfg.height));
		err_sub = error_q - $signed({2'b00, minor_delta_q});
		err_add = err_sub + $signed({2'b00, major_delta_q});
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q    <= '0;
			minor_pos_q    <= '0;
			major_end_q    <= '0;
			major_delta_q  <= '0;
			minor_delta_q  <= '0;
			error_q        <= '0;
			minor_down_q   <= 1'b0;
			axes_swapped_q <= 1'b0;
			held_color_q   <= '0;
			drawing_q      <= 1'b0;
		end else if (do_pop && !is_step) begin
			major_pos_q    <= pop_cmd.major_start;
			minor_pos_q    <= pop_cmd.minor_start;
			major_end_q    <= pop_cmd.major_end;
			major_delta_q  <= pop_cmd.major_delta;
			minor_delta_q  <= pop_cmd.minor_delta;
			error_q        <= $signed({2'b00, pop_cmd.major_delta >> 1});
			minor_down_q   <= pop_cmd.minor_down;
			axes_swapped_q <= pop_cmd.axes_swapped;
			held_color_q   <= pop_cmd.color;
			drawing_q      <= 1'b1;
		end else if (emit) begin
			if (last) begin
				drawing_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + 1'b1;
				if (err_sub < 0) begin
					minor_pos_q <= minor_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
					error_q     <= err_add;
				end else begin
					error_q <= err_sub;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.pixel_x     <= px;
			out_item_q.pixel_y     <= py;
			out_item_q.pixel_color <= held_color_q;
			out_item_q.on_screen   <= vis;
			out_item_q.last_pixel  <= last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_item       = out_item_q;
	assign status.drawing = drawing_q;
	assign status.pop     = do_pop;
	assign status.emit    = emit;

endmodule

// ===== hw/rtl/bresenham_line_pixel_generator_top.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_top: line pixel engine
// Input channel in_valid/in_ready/in_item carries load and step items; output
// channel out_valid/out_ready/out_item carries one pixel per step item while
// a line is being drawn. A load item sets up a new line (abandoning any old
// one) and gives no pixel; a step item while idle gives no pixel.
// Throughput: one item per cycle while out_ready holds; the stepper does one
// add and compare on the error term per pixel.
// Path: a step item passes the intake register, the command queue and the
// output register, in that order, before its pixel is presented.
// The front and back are parted by a two-entry command queue; when the
// receiver stalls, the output register holds its pixel, the back stops on the
// next drawing step, and the queue and intake register fill before in_ready
// drops. Loads and idle steps still drain while a pixel waits.
// Reset: asynchronous, active low; the line engine goes idle, the queue
// empties, and the screen size returns to 240 by 320.
// Configuration: cfg_wr_en with cfg_addr 0 (width) or 1 (height) writes
// cfg_wdata at the clock edge; write only while the block is idle.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bpg_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [bpg_pkg::REG_BITS-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bpg_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bpg_pkg::out_item_t                  out_item
);

	bpg_pkg::screen_cfg_t  screen_cfg_q;
	logic                  push_valid;
	logic                  push_ready;
	bpg_pkg::cmd_t         push_cmd;
	logic                  pop_valid;
	logic                  pop_ready;
	bpg_pkg::cmd_t         pop_cmd;
	bpg_pkg::back_status_t back_status;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_cfg_q.width  <= bpg_pkg::SCREEN_WIDTH_RST;
			screen_cfg_q.height <= bpg_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				bpg_pkg::REG_SCREEN_WIDTH: begin
					screen_cfg_q.width <= cfg_wdata;
				end
				bpg_pkg::REG_SCREEN_HEIGHT: begin
					screen_cfg_q.height <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	bpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	bpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	bpg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.screen_cfg (screen_cfg_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.status     (back_status)
	);

`ifndef NO_ASSERTIONS
	// a popped load always leaves the engine drawing
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(back_status.pop && pop_cmd.func == bpg_pkg::FUNC_LOAD) |=> back_status.drawing)
		else $error("load did not start a line");

	// a pixel is only produced while a line is active
	a_emit_drawing: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.emit |-> back_status.drawing)
		else $error("pixel emitted while idle");

	// a waiting pixel is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !back_status.emit)
		else $error("pending pixel overwritten");

	// the last pixel of a line ends drawing, any other pixel keeps it going
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.emit |=> (out_item.last_pixel != back_status.drawing))
		else $error("line did not end after its last pixel");
`endif

endmodule
